// ----- sv/fdt_pkg.sv -----
// Package: shared constants and types for the truncating float32 divider.
package fdt_pkg;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned ManWidth  = 23;
   localparam int unsigned ExpWidth  = 8;
   localparam int unsigned DvdWidth  = 31;
   localparam int unsigned DvsWidth  = 17;
   localparam int unsigned QuoWidth  = 15;
   localparam int unsigned DivSteps  = 15;
   localparam int unsigned StepWidth = 4;
   localparam logic [8:0]  BiasAdj   = 9'd136;

   typedef struct packed {
      logic load;
      logic step;
      logic norm;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic norm_done;
   } sts_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_NORM = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;
endpackage

// ----- sv/fdt_datapath.sv -----
// Datapath: restoring divider, normalizer and result packing.
module fdt_datapath (
   input  logic             clock,
   input  fdt_pkg::cmd_type cmd,
   output fdt_pkg::sts_type sts,
   input  logic [31:0]      req_dividend_bits,
   input  logic [31:0]      req_divisor_bits,
   output logic [31:0]      quotient
);
   logic [fdt_pkg::DvsWidth:0]     rem_ff, rem_in;
   logic [fdt_pkg::DvdWidth-1:0]   dvd_ff, dvd_in;
   logic [fdt_pkg::DvsWidth-1:0]   dvs_ff, dvs_in;
   logic [fdt_pkg::ManWidth:0]     quo_ff, quo_in;
   logic [8:0]                     exp_ff, exp_in;
   logic                           sgn_ff, sgn_in;
   logic                           zero_ff, zero_in;
   logic [fdt_pkg::StepWidth-1:0]  cnt_ff, cnt_in;
   logic [fdt_pkg::DvsWidth:0]     trial;
   logic [fdt_pkg::DvsWidth:0]     diff;

   assign trial = {rem_ff[fdt_pkg::DvsWidth-1:0], dvd_ff[fdt_pkg::DvdWidth-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      exp_in  = exp_ff;
      sgn_in  = sgn_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         rem_in  = {{(fdt_pkg::DvsWidth - 15){1'b0}}, 1'b1,
                    req_dividend_bits[22:8]};
         dvd_in  = {req_dividend_bits[7:0], 7'd0, 16'd0};
         dvs_in  = {1'b1, req_divisor_bits[22:7]};
         quo_in  = '0;
         exp_in  = {1'b0, req_dividend_bits[30:23]} - {1'b0, req_divisor_bits[30:23]};
         sgn_in  = req_dividend_bits[31] ^ req_divisor_bits[31];
         zero_in = (req_dividend_bits[30:0] == 31'd0);
         cnt_in  = '0;
      end else if (cmd.step) begin
         dvd_in = {dvd_ff[fdt_pkg::DvdWidth-2:0], 1'b0};
         if (!diff[fdt_pkg::DvsWidth]) begin
            rem_in = diff;
            quo_in = {quo_ff[fdt_pkg::ManWidth-1:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[fdt_pkg::ManWidth-1:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.norm && !quo_ff[fdt_pkg::ManWidth]) begin
         quo_in = {quo_ff[fdt_pkg::ManWidth-1:0], 1'b0};
         exp_in = exp_ff - 9'd1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      exp_ff  <= exp_in;
      sgn_ff  <= sgn_in;
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
   end

   logic [8:0] exp_fin;
   assign exp_fin = exp_ff + fdt_pkg::BiasAdj;

   assign sts.div_done  = (cnt_ff == fdt_pkg::StepWidth'(fdt_pkg::DivSteps - 1));
   assign sts.norm_done = quo_ff[fdt_pkg::ManWidth];
   assign quotient = zero_ff ? 32'd0 :
      {sgn_ff | exp_fin[8], exp_fin[7:0], quo_ff[fdt_pkg::ManWidth-1:0]};
endmodule

// ----- sv/fdt_control.sv -----
// Controller: sequences load, divide steps, normalize and result hold.
module fdt_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fdt_pkg::cmd_type cmd,
   input  fdt_pkg::sts_type sts
);
   fdt_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         fdt_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = fdt_pkg::ST_DIV;
            end
         end
         fdt_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            if (sts.div_done) state_in = fdt_pkg::ST_NORM;
         end
         fdt_pkg::ST_NORM: begin
            cmd.norm = 1'b1;
            if (sts.norm_done) state_in = fdt_pkg::ST_OUT;
         end
         fdt_pkg::ST_OUT: begin
            if (!rsp_stall) state_in = fdt_pkg::ST_IDLE;
         end
         default: state_in = fdt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= fdt_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_stall = (state_ff != fdt_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == fdt_pkg::ST_OUT);

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == fdt_pkg::ST_DIV)
      else $error("transfer did not start division");
   a_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> state_ff == fdt_pkg::ST_IDLE)
      else $error("result transfer did not return to idle");
endmodule

// ----- sv/float32_divider_truncating.sv -----
// Top level: truncating single-precision divider.
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_dividend_bits, req_divisor_bits
//  rsp     | out       | rsp_valid / rsp_stall | rsp_quotient_bits
// A result is ready for transfer after its input transfer has gone through the restoring
// divide steps, the normalize shifts, the exit from normalize and the result state.
// The next input transfer can come in the cycle after the result transfer.
// The single shift-subtract unit sets the rate; one item is in flight.
// Reset is synchronous and returns the controller to idle.
module float32_divider_truncating (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_dividend_bits,
   input  logic [31:0] req_divisor_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_quotient_bits
);
   fdt_pkg::cmd_type cmd;
   fdt_pkg::sts_type sts;

   fdt_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts
   );

   fdt_datapath u_datapath (
      .clock, .cmd, .sts, .req_dividend_bits, .req_divisor_bits,
      .quotient(rsp_quotient_bits)
   );
endmodule
